### rtl/egcd_pkg.sv
// package: shared constants and sequencer state type for the extended gcd block
package egcd_pkg;

  // default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

### rtl/egcd_if.sv
// interfaces: operand request channel and coefficient response channel

interface egcd_req_if #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_rsp_if #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] coef_x;
  logic signed [DATA_WIDTH-1:0] coef_y;
  logic        [DATA_WIDTH-2:0] gcd_value;

  modport source (output valid, output coef_x, output coef_y, output gcd_value, input ready);
  modport sink   (input valid, input coef_x, input coef_y, input gcd_value, output ready);
endinterface

### rtl/extended_gcd_bezout_top.sv
// top level: iterative extended euclidean unit returning bezout coefficients and gcd
//
// Takes signed operands a and b and returns x, y with a*x + b*y = gcd(|a|,|b|), plus the
// gcd. One item at a time: each quotient step runs a restoring divider one quotient bit
// per cycle while the same bits drive shift-add accumulation of the two new convergents,
// then an update state merges them and a check state tests for a zero remainder. At 32
// bits an item needs at most about 46 quotient steps, and far fewer for typical operands.
// A zero operand goes from the check state straight to the finish state. The result sits
// in an output register, and the next item is taken while it waits; a finished item holds
// in the last state only if the previous result has not yet been taken. The most negative
// operand value is outside the supported range.
module extended_gcd_bezout_top #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  egcd_req_if.sink  req,
  egcd_rsp_if.source rsp
);
  import egcd_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  state_t state, state_next;

  // operand magnitudes, signs and convergent matrix
  logic [DATA_WIDTH-1:0] a, b;
  logic                  na, nb;
  logic                  a_smaller;
  logic                  a_gt;
  logic                  odd;
  logic [DATA_WIDTH-1:0] c11, c12, c21, c22;

  // divider and accumulator registers
  logic [DATA_WIDTH-1:0] dvd, dvs, rem;
  logic [DATA_WIDTH-1:0] acc1, acc2;
  logic [CNT_W-1:0]      cnt;

  logic                  out_valid;
  logic [DATA_WIDTH-1:0] coef_x, coef_y;
  logic [DATA_WIDTH-2:0] gcd_value;

  // combinational helpers
  logic                  req_xfer;
  logic                  rsp_free;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] xm, ym, gsel;
  logic                  xn, yn;

  assign req_xfer = req.valid && req.ready;
  assign rsp_free = !out_valid || rsp.ready;

  // one restoring division step
  assign trial = {rem, dvd[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = !diff[DATA_WIDTH];

  // coefficient selection from previous convergents and step parity
  always_comb begin
    if (a_smaller) begin
      xm = c12;
      xn = na ^ !odd;
      ym = c22;
      yn = nb ^ odd;
    end else begin
      xm = c22;
      xn = na ^ odd;
      ym = c12;
      yn = nb ^ !odd;
    end
    if (xm == '0) xn = 1'b0;
    if (ym == '0) yn = 1'b0;
    gsel = (a != '0) ? a : b;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = ST_START;
      end
      ST_START: state_next = ST_CHECK;
      ST_CHECK: begin
        if (a == '0 || b == '0) state_next = ST_FINISH;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_CHECK;
      ST_FINISH: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && rsp_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          na  <= req.operand_a[DATA_WIDTH-1];
          nb  <= req.operand_b[DATA_WIDTH-1];
          a   <= req.operand_a[DATA_WIDTH-1] ? -req.operand_a : req.operand_a;
          b   <= req.operand_b[DATA_WIDTH-1] ? -req.operand_b : req.operand_b;
          c11 <= DATA_WIDTH'(1);
          c12 <= '0;
          c21 <= '0;
          c22 <= DATA_WIDTH'(1);
          odd <= 1'b0;
        end
      end
      ST_START: a_smaller <= (a < b);
      ST_CHECK: begin
        // larger value is the dividend, equal magnitudes divide b by a
        a_gt <= (a > b);
        dvd  <= (a > b) ? a : b;
        dvs  <= (a > b) ? b : a;
        rem  <= '0;
        acc1 <= '0;
        acc2 <= '0;
        cnt  <= CNT_W'(DATA_WIDTH - 1);
      end
      ST_DIV: begin
        // quotient bits feed horner accumulation of q*c11 and q*c21
        rem  <= qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        dvd  <= {dvd[DATA_WIDTH-2:0], 1'b0};
        acc1 <= {acc1[DATA_WIDTH-2:0], 1'b0} + (qbit ? c11 : '0);
        acc2 <= {acc2[DATA_WIDTH-2:0], 1'b0} + (qbit ? c21 : '0);
        cnt  <= cnt - CNT_W'(1);
      end
      ST_UPDATE: begin
        if (a_gt) a <= rem;
        else b <= rem;
        c11 <= acc1 + c12;
        c12 <= c11;
        c21 <= acc2 + c22;
        c22 <= c21;
        odd <= !odd;
      end
      ST_FINISH: begin
        if (rsp_free) begin
          coef_x    <= xn ? -xm : xm;
          coef_y    <= yn ? -ym : ym;
          // saturate a gcd of 2^(w-1), reachable only with the most negative operand
          gcd_value <= gsel[DATA_WIDTH-1] ? '1 : gsel[DATA_WIDTH-2:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid     = out_valid;
  assign rsp.coef_x    = coef_x;
  assign rsp.coef_y    = coef_y;
  assign rsp.gcd_value = gcd_value;

endmodule

### rtl/egcd_checker.sv
// checker: port-level assertions for the extended gcd top level, with its bind
module egcd_checker #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] coef_x,
  input logic [DATA_WIDTH-1:0] coef_y
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // an accepted item occupies the unit for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while unit busy");

  // when a new result appears, the unit has returned to accepting items
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result produced while unit still busy");

  // the coefficients never both vanish
  a_coef_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coef_x != '0 || coef_y != '0))
    else $error("both coefficients zero");

endmodule

bind extended_gcd_bezout_top egcd_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_egcd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (req.valid),
  .in_ready (req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .coef_x   (rsp.coef_x),
  .coef_y   (rsp.coef_y)
);
